>>> rtl/swc3_pkg.sv
// package: types, constants and pair tables for the sliding window covariance block
`timescale 1ns / 1ps
package swc3_pkg;

    localparam int MAX_WINDOW  = 128;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(MAX_WINDOW);
    localparam int COUNT_W     = $clog2(MAX_WINDOW + 1);
    localparam int ASUM_W      = SAMPLE_BITS + ADDR_W + 1;
    localparam int PSUM_W      = 2 * SAMPLE_BITS + ADDR_W + 1;
    localparam int MUL_A_W     = PSUM_W;
    localparam int MUL_B_W     = ASUM_W;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int NUM_W       = PSUM_W + COUNT_W;
    localparam int DEN_W       = 2 * COUNT_W;
    localparam int WORD_W      = 3 * SAMPLE_BITS;
    localparam int NUM_AXES    = 3;
    localparam int NUM_PAIRS   = 6;
    localparam int COV_W       = 32;
    localparam int WIN_W       = 8;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 8'd100;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] err_x;
        logic signed [SAMPLE_BITS-1:0] err_y;
        logic signed [SAMPLE_BITS-1:0] err_z;
        logic                          sample_invalid;
    } in_item_t;

    typedef struct packed {
        logic signed [COV_W-1:0] cov_xx;
        logic signed [COV_W-1:0] cov_yy;
        logic signed [COV_W-1:0] cov_zz;
        logic signed [COV_W-1:0] cov_xy;
        logic signed [COV_W-1:0] cov_xz;
        logic signed [COV_W-1:0] cov_yz;
        logic [WIN_W-1:0]        sample_count;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_EV_READ,
        S_ACC,
        S_COV_DEN,
        S_COV_MUL1,
        S_COV_MUL2,
        S_COV_SUB,
        S_COV_START,
        S_COV_DIV,
        S_DONE
    } state_t;

    // first axis of each covariance pair: xx yy zz xy xz yz
    function automatic logic [1:0] pair_a(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd0;
            3'd4:    r = 2'd0;
            3'd5:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // second axis of each covariance pair
    function automatic logic [1:0] pair_b(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd1;
            3'd4:    r = 2'd2;
            3'd5:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/swc3_store.sv
// sample window memory: one write port, one registered read port
`timescale 1ns / 1ps
module swc3_store
    import swc3_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [MAX_WINDOW];
    logic [WORD_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/swc3_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module swc3_mul
    import swc3_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] p
);

    logic signed [MUL_P_W-1:0] p_reg;

    // one product per cycle
    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

>>> rtl/swc3_div.sv
// serial restoring divider, truncating toward zero, saturated to 32 bits
`timescale 1ns / 1ps
module swc3_div
    import swc3_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic signed [COV_W-1:0] q
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] mag_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_shift;
    logic             fits;
    logic [NUM_W-1:0] num_mag;

    assign num_mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign rem_shift = {rem_reg[DEN_W-1:0], mag_reg[NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    // one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // payload of the divider
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= num_mag;
            neg_reg <= num[NUM_W-1];
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_shift - {1'b0, den_reg}) : rem_shift;
            mag_reg <= {mag_reg[NUM_W-2:0], fits};
        end
    end

    // sign and saturation
    always_comb
    begin
        if (neg_reg)
        begin
            if (mag_reg > NUM_W'(64'h8000_0000))
            begin
                q = 32'sh8000_0000;
            end
            else
            begin
                q = COV_W'(-mag_reg[COV_W-1:0]);
            end
        end
        else
        begin
            if (mag_reg > NUM_W'(64'h7FFF_FFFF))
            begin
                q = 32'sh7FFF_FFFF;
            end
            else
            begin
                q = mag_reg[COV_W-1:0];
            end
        end
    end

    assign done = done_reg;

    // the divider never reports done while still shifting
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

    // a start always leads into a busy divider
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && !done_reg)
        else $error("divider did not start");

    // a finished division follows the last shift
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == CNT_W'(1) && !start) |=> done_reg)
        else $error("divider did not finish");

endmodule

>>> rtl/sliding_window_covariance_3d.sv
// top level: sliding window 3x3 sample covariance with a shared multiplier and serial divider
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    in_data  (in_item_t)
//  out       output     out_valid / out_stall  out_data (out_item_t)
//  cfg       input      cfg_wr_en              cfg_wr_data (window_len)
//
// a valid sample passes a check state, then a memory read and six passes of the shared
// multiplier for each evicted sample, then six passes to add it; the covariance is then
// worked out pair by pair with the shared multiplier and the one-bit-per-cycle divider.
// fewer than two samples skip the divider. in_stall is high from acceptance until the
// result is loaded into the output register, which may still wait on out_stall.
// reset clears counts and sums; the sample memory is not cleared.
`timescale 1ns / 1ps
module sliding_window_covariance_3d
    import swc3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_wr_en,
    input  logic [WIN_W-1:0] cfg_wr_data
);

    state_t state_reg, state_next;

    logic [WIN_W-1:0]              window_len_reg;
    logic [COUNT_W-1:0]            count_reg;
    logic [ADDR_W-1:0]             oldest_reg;
    logic signed [ASUM_W-1:0]      asum_reg [NUM_AXES];
    logic signed [PSUM_W-1:0]      psum_reg [NUM_PAIRS];
    logic signed [SAMPLE_BITS-1:0] new_reg  [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] cur_reg  [NUM_AXES];
    logic signed [COV_W-1:0]       res_reg  [NUM_PAIRS];
    logic                          evict_reg;
    logic [2:0]                    step_reg;
    logic [2:0]                    k_reg;
    logic signed [NUM_W-1:0]       num_reg;
    logic [DEN_W-1:0]              den_reg;
    out_item_t                     out_reg;
    logic                          out_valid_reg;

    logic [COUNT_W-1:0]        win_eff;
    logic                      in_fire;
    logic                      need_evict;
    logic                      out_free;
    logic                      mem_wr_en;
    logic                      mem_rd_en;
    logic [ADDR_W-1:0]         wr_slot;
    logic [WORD_W-1:0]         mem_rd_data;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic                      div_start;
    logic                      div_done;
    logic signed [COV_W-1:0]   div_q;
    logic [2:0]                acc_idx;
    logic signed [PSUM_W-1:0]  prod_term;

    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign wr_slot  = oldest_reg + count_reg[ADDR_W-1:0];
    assign acc_idx  = step_reg - 3'd1;
    assign prod_term = evict_reg ? -PSUM_W'(mul_p) : PSUM_W'(mul_p);

    // effective window length: zero counts as one, clipped to the memory depth
    always_comb
    begin
        if (window_len_reg == '0)
        begin
            win_eff = COUNT_W'(1);
        end
        else if (COUNT_W'(window_len_reg) > COUNT_W'(MAX_WINDOW))
        begin
            win_eff = COUNT_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = COUNT_W'(window_len_reg);
        end
    end

    assign need_evict = (count_reg >= win_eff) && (count_reg != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = in_data.sample_invalid ? S_COV_DEN : S_CHECK;
                end
            end
            S_CHECK:     state_next = need_evict ? S_EV_READ : S_ACC;
            S_EV_READ:   state_next = S_ACC;
            S_ACC:
            begin
                if (step_reg == 3'd6)
                begin
                    state_next = evict_reg ? S_CHECK : S_COV_DEN;
                end
            end
            S_COV_DEN:   state_next = (count_reg < COUNT_W'(2)) ? S_DONE : S_COV_MUL1;
            S_COV_MUL1:  state_next = S_COV_MUL2;
            S_COV_MUL2:  state_next = S_COV_SUB;
            S_COV_SUB:   state_next = S_COV_START;
            S_COV_START: state_next = S_COV_DIV;
            S_COV_DIV:
            begin
                if (div_done)
                begin
                    state_next = (k_reg == 3'd5) ? S_DONE : S_COV_MUL1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // sequencer outputs: memory strobes, multiplier operands, divider start
    always_comb
    begin
        in_stall  = 1'b1;
        mem_wr_en = 1'b0;
        mem_rd_en = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            S_IDLE:      in_stall = 1'b0;
            S_CHECK:
            begin
                mem_rd_en = need_evict;
                mem_wr_en = !need_evict;
            end
            S_ACC:
            begin
                mul_a = MUL_A_W'(cur_reg[pair_a(step_reg)]);
                mul_b = MUL_B_W'(cur_reg[pair_b(step_reg)]);
            end
            S_COV_DEN:
            begin
                mul_a = signed'(MUL_A_W'(count_reg));
                mul_b = signed'(MUL_B_W'(count_reg - 1'b1));
            end
            S_COV_MUL1:
            begin
                mul_a = psum_reg[k_reg];
                mul_b = signed'(MUL_B_W'(count_reg));
            end
            S_COV_MUL2:
            begin
                mul_a = MUL_A_W'(asum_reg[pair_a(k_reg)]);
                mul_b = MUL_B_W'(asum_reg[pair_b(k_reg)]);
            end
            S_COV_START: div_start = 1'b1;
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            window_len_reg <= WINDOW_RESET;
            count_reg      <= '0;
            oldest_reg     <= '0;
            step_reg       <= '0;
            k_reg          <= '0;
            evict_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                asum_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_PAIRS; i++)
            begin
                psum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                window_len_reg <= cfg_wr_data;
            end
            // result register: load from the done state, clear on acceptance
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CHECK:
                begin
                    evict_reg <= need_evict;
                    step_reg  <= '0;
                end
                S_ACC:
                begin
                    step_reg <= step_reg + 1'b1;
                    // axis sums on the first pass, product sums trail the multiplier
                    if (step_reg == 3'd0)
                    begin
                        for (int i = 0; i < NUM_AXES; i++)
                        begin
                            asum_reg[i] <= evict_reg ? asum_reg[i] - ASUM_W'(cur_reg[i])
                                                     : asum_reg[i] + ASUM_W'(cur_reg[i]);
                        end
                    end
                    else
                    begin
                        psum_reg[acc_idx] <= psum_reg[acc_idx] + prod_term;
                    end
                    if (step_reg == 3'd6)
                    begin
                        if (evict_reg)
                        begin
                            oldest_reg <= oldest_reg + 1'b1;
                            count_reg  <= count_reg - 1'b1;
                        end
                        else
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                S_COV_DEN:   k_reg <= '0;
                S_COV_DIV:
                begin
                    if (div_done)
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            new_reg[0] <= in_data.err_x;
            new_reg[1] <= in_data.err_y;
            new_reg[2] <= in_data.err_z;
        end
        if (state_reg == S_CHECK && !need_evict)
        begin
            cur_reg <= new_reg;
        end
        if (state_reg == S_EV_READ)
        begin
            cur_reg[0] <= mem_rd_data[WORD_W-1 -: SAMPLE_BITS];
            cur_reg[1] <= mem_rd_data[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
            cur_reg[2] <= mem_rd_data[SAMPLE_BITS-1:0];
        end
        if (state_reg == S_COV_DEN)
        begin
            for (int i = 0; i < NUM_PAIRS; i++)
            begin
                res_reg[i] <= '0;
            end
        end
        if (state_reg == S_COV_MUL1 && k_reg == 3'd0)
        begin
            den_reg <= DEN_W'(mul_p);
        end
        if (state_reg == S_COV_MUL2)
        begin
            num_reg <= NUM_W'(mul_p);
        end
        if (state_reg == S_COV_SUB)
        begin
            num_reg <= num_reg - NUM_W'(mul_p);
        end
        if (state_reg == S_COV_DIV && div_done)
        begin
            res_reg[k_reg] <= div_q;
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_reg.cov_xx       <= res_reg[0];
            out_reg.cov_yy       <= res_reg[1];
            out_reg.cov_zz       <= res_reg[2];
            out_reg.cov_xy       <= res_reg[3];
            out_reg.cov_xz       <= res_reg[4];
            out_reg.cov_yz       <= res_reg[5];
            out_reg.sample_count <= WIN_W'(count_reg);
        end
    end

    // sample memory
    swc3_store u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_slot),
        .wr_data ({new_reg[0], new_reg[1], new_reg[2]}),
        .rd_en   (mem_rd_en),
        .rd_addr (oldest_reg),
        .rd_data (mem_rd_data)
    );

    // shared multiplier
    swc3_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // serial divider
    swc3_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .q     (div_q)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // the window never holds more than the memory depth
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_WINDOW))
        else $error("sample count above depth");

    // an accepted transaction makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> in_stall)
        else $error("block not busy after accept");

    // the window is untouched while idle
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && $past(state_reg == S_IDLE)) |-> $stable(count_reg))
        else $error("count changed while idle");

    // fewer than two samples give zero covariance
    a_small_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.sample_count < WIN_W'(2))
            |-> (out_reg.cov_xx == '0 && out_reg.cov_xy == '0 && out_reg.cov_yz == '0))
        else $error("nonzero covariance for short window");

endmodule

>>> test/tb_sliding_window_covariance_3d.sv
// testbench: random and directed check of the sliding window covariance block
`timescale 1ns / 1ps
module tb_sliding_window_covariance_3d
    import swc3_pkg::*;
();

    // covariance predictor and store of expected results
    class cov_board;
        logic signed [SAMPLE_BITS-1:0] win_mem [MAX_WINDOW][NUM_AXES];
        int unsigned head;
        int unsigned held;
        longint lin_sum [NUM_AXES];
        longint sq_sum [NUM_PAIRS];
        int unsigned win_len;
        out_item_t pending [$];
        int errors;
        int checked;

        function new();
            head = 0;
            held = 0;
            win_len = WINDOW_RESET;
            errors = 0;
            checked = 0;
            foreach (lin_sum[k]) lin_sum[k] = 0;
            foreach (sq_sum[k]) sq_sum[k] = 0;
        endfunction

        function void set_window(logic [WIN_W-1:0] v);
            win_len = v;
        endfunction

        function int axis_a(int k);
            int t [NUM_PAIRS] = '{0, 1, 2, 0, 0, 1};
            return t[k];
        endfunction

        function int axis_b(int k);
            int t [NUM_PAIRS] = '{0, 1, 2, 1, 2, 2};
            return t[k];
        endfunction

        // add or remove one sample from the running sums
        function void fold(longint s [NUM_AXES], longint sgn);
            for (int k = 0; k < NUM_AXES; k++)
                lin_sum[k] += sgn * s[k];
            for (int k = 0; k < NUM_PAIRS; k++)
                sq_sum[k] += sgn * s[axis_a(k)] * s[axis_b(k)];
        endfunction

        function logic signed [COV_W-1:0] entry(int k);
            longint n;
            longint q;
            n = held;
            if (n < 2)
                return '0;
            q = (n * sq_sum[k] - lin_sum[axis_a(k)] * lin_sum[axis_b(k)]) / (n * (n - 1));
            if (q > 64'sd2147483647)
                q = 64'sd2147483647;
            if (q < -64'sd2147483648)
                q = -64'sd2147483648;
            return q[COV_W-1:0];
        endfunction

        // accepted input transaction: update window, queue expected covariance
        function void note_sample(in_item_t it);
            longint s [NUM_AXES];
            longint old [NUM_AXES];
            int unsigned w;
            int unsigned slot;
            logic signed [COV_W-1:0] c [NUM_PAIRS];
            out_item_t e;
            if (!it.sample_invalid)
            begin
                w = (win_len == 0) ? 1 : win_len;
                if (w > MAX_WINDOW)
                    w = MAX_WINDOW;
                s[0] = it.err_x;
                s[1] = it.err_y;
                s[2] = it.err_z;
                while (held >= w && held > 0)
                begin
                    for (int k = 0; k < NUM_AXES; k++)
                        old[k] = win_mem[head][k];
                    fold(old, -1);
                    head = (head + 1) % MAX_WINDOW;
                    held--;
                end
                slot = (head + held) % MAX_WINDOW;
                win_mem[slot][0] = it.err_x;
                win_mem[slot][1] = it.err_y;
                win_mem[slot][2] = it.err_z;
                fold(s, 1);
                held++;
            end
            for (int k = 0; k < NUM_PAIRS; k++)
                c[k] = entry(k);
            e.cov_xx = c[0];
            e.cov_yy = c[1];
            e.cov_zz = c[2];
            e.cov_xy = c[3];
            e.cov_xz = c[4];
            e.cov_yz = c[5];
            e.sample_count = held[WIN_W-1:0];
            pending.insert(pending.size(), e);
        endfunction

        function void cmp(string name, longint expv, longint actv);
            if (expv != actv)
            begin
                $error("%s mismatch: expected %0d actual %0d", name, expv, actv);
                errors++;
            end
        endfunction

        // accepted output transaction against oldest expectation
        function void check_result(out_item_t r);
            out_item_t e;
            if (pending.size() == 0)
            begin
                $error("result with no expectation: count %0d", r.sample_count);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            cmp("cov_xx", e.cov_xx, r.cov_xx);
            cmp("cov_yy", e.cov_yy, r.cov_yy);
            cmp("cov_zz", e.cov_zz, r.cov_zz);
            cmp("cov_xy", e.cov_xy, r.cov_xy);
            cmp("cov_xz", e.cov_xz, r.cov_xz);
            cmp("cov_yz", e.cov_yz, r.cov_yz);
            cmp("sample_count", e.sample_count, r.sample_count);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_wr_en;
    logic [WIN_W-1:0] cfg_wr_data;

    cov_board board;
    int idle_cycles = 0;
    bit long_hold_req = 1'b0;
    int sent;
    int phases;

    sliding_window_covariance_3d dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // gap length: mostly short, a few long
    function int pick_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 400);
        return $urandom_range(0, 4);
    endfunction

    function logic signed [SAMPLE_BITS-1:0] pick_axis(int base);
        case ($urandom_range(0, 5))
            0: return SAMPLE_BITS'($urandom());
            1: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            2: return SAMPLE_BITS'(base);
            default: return SAMPLE_BITS'(base + $signed($urandom_range(0, 512)) - 256);
        endcase
    endfunction

    // send one input transaction, valid held high until accepted
    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] x,
                               logic signed [SAMPLE_BITS-1:0] y,
                               logic signed [SAMPLE_BITS-1:0] z, logic bad);
        int gap;
        in_item_t it;
        gap = pick_gap();
        it.err_x = x;
        it.err_y = y;
        it.err_z = z;
        it.sample_invalid = bad;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_sample(it);
        sent++;
    endtask

    // drain outstanding results, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_window(logic [WIN_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_window(v);
        phases++;
    endtask

    task automatic random_run(int count);
        int base [NUM_AXES];
        for (int k = 0; k < NUM_AXES; k++)
            base[k] = $signed($urandom_range(0, 16000)) - 8000;
        for (int i = 0; i < count; i++)
            send_sample(pick_axis(base[0]), pick_axis(base[1]), pick_axis(base[2]),
                        $urandom_range(0, 9) == 0);
    endtask

    // receiver: random stalls, one requested long hold-off
    initial
    begin
        int hold;
        bit long_done;
        hold = 0;
        long_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_result(out_data);
            if (long_hold_req && !long_done)
            begin
                long_done = 1'b1;
                hold = 3000;
            end
            else if (hold == 0 && $urandom_range(0, 2) == 0)
            begin
                hold = pick_gap();
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [WIN_W-1:0] wins [8];
        wins = '{8'd7, 8'd128, 8'd3, 8'd255, 8'd0, 8'd40, 8'd2, 8'd90};
        board = new();
        sent = 0;
        phases = 0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty window, invalid on empty, extremes, single-sample window
        send_sample(16'sh7fff, 16'sh8000, 16'sh0000, 1'b1);
        send_sample(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
        send_sample(16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
        send_sample(16'sh0000, 16'shffff, 16'sh0001, 1'b0);
        send_sample(-16'sd4096, 16'sd4096, 16'sd12, 1'b0);
        drain();
        write_window(8'd1);
        send_sample(16'sd100, 16'sd200, 16'sd300, 1'b0);
        send_sample(16'sd5, -16'sd5, 16'sd9, 1'b0);
        drain();
        write_window(8'd4);
        for (int i = 0; i < 6; i++)
            send_sample(SAMPLE_BITS'(16'sh7fff ^ i), SAMPLE_BITS'(16'sh8000 + i),
                        SAMPLE_BITS'(i * 1000), i == 3);
        drain();
        // shorten the window on a full window: many evictions on the next valid sample
        write_window(8'd2);
        send_sample(16'sd1, 16'sd2, 16'sd3, 1'b1);
        send_sample(16'sd1, 16'sd2, 16'sd3, 1'b0);
        send_sample(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
        drain();

        // long receiver hold-off while the sender keeps offering
        long_hold_req = 1'b1;
        random_run(12);

        // random phases across window settings, extremes included
        foreach (wins[p])
        begin
            drain();
            write_window(p == 7 ? WIN_W'($urandom_range(1, 128)) : wins[p]);
            random_run(p == 1 ? 240 : 95);
        end
        drain();

        $display("covered %0d samples, %0d results checked, %0d window settings",
                 sent, board.checked, phases);
        $display("window lengths 0..255, eviction on shortening, invalid samples, stalls");
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/swc3_pkg.sv
rtl/swc3_store.sv
rtl/swc3_mul.sv
rtl/swc3_div.sv
rtl/sliding_window_covariance_3d.sv
test/tb_sliding_window_covariance_3d.sv
